@@ hdl/bhq_pkg.sv @@
// shared types, constants and helpers for the binary max heap queue
`timescale 1ns / 1ps
`default_nettype none

package bhq_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int COUNT_W    = $clog2(CAPACITY + 1);

    typedef logic signed [DATA_WIDTH-1:0] key_t;
    typedef logic [COUNT_W-1:0]           count_t;

    typedef enum logic
    {
        KIND_PUSH = 1'b0,
        KIND_POP  = 1'b1
    } kind_t;

    typedef enum logic [1:0]
    {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // operation broadcast to every cell of the row
    typedef struct packed
    {
        logic push;
        logic pop;
        key_t key;
    } cell_ctrl_t;

    // signed resize in either direction
    function automatic key_t to_key(logic signed [31:0] v);
        return key_t'(v);
    endfunction

    function automatic logic signed [31:0] from_key(key_t k);
        return 32'(k);
    endfunction

endpackage

`default_nettype wire

@@ hdl/bhq_cell.sv @@
// one slot of the sorted row: holds a value and shifts with its neighbors
`timescale 1ns / 1ps
`default_nettype none

module bhq_cell
(
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire bhq_pkg::cell_ctrl_t  ctrl,
    input  wire                       prev_valid,
    input  wire                       prev_gt,
    input  wire bhq_pkg::key_t        prev_data,
    input  wire                       next_valid,
    input  wire bhq_pkg::key_t        next_data,
    output logic                      valid,
    output bhq_pkg::key_t             data,
    output logic                      gt,
    output logic                      valid_next,
    output bhq_pkg::key_t             data_next
);

    logic          valid_reg;
    bhq_pkg::key_t data_reg;

    // the new key belongs at or before this slot
    assign gt = !valid_reg || (ctrl.key > data_reg);

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (ctrl.push)
        begin
            valid_next = valid_reg || prev_valid;
            if (gt)
            begin
                data_next = prev_gt ? prev_data : ctrl.key;
            end
        end
        else if (ctrl.pop)
        begin
            valid_next = next_valid;
            data_next  = next_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

`default_nettype wire

@@ hdl/binary_max_heap_queue.sv @@
// top level of the max priority queue: cell row, fill count and result register
`timescale 1ns / 1ps
`default_nettype none

// Max priority queue of up to CAPACITY signed values, kept as a row of cells
// sorted in descending order. Every cell compares the pushed value against its
// own entry and shifts toward its neighbor in the same cycle, so a push or a pop
// of any item is done over the whole row at once: an accepted item gives its
// result in the next cycle from the output register, and a new item is taken every cycle
// while the result side does not stall. A pop on empty or a push on full leaves
// the contents untouched and is flagged in status.

module binary_max_heap_queue
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  wire                 kind,
    input  wire signed [31:0]   value,
    output logic                out_valid,
    input  wire                 out_stall,
    output logic signed [31:0]  popped_value,
    output logic signed [31:0]  top_value,
    output logic [6:0]          entry_count,
    output logic [1:0]          status
);

    localparam int N = bhq_pkg::CAPACITY;

    logic                 cell_valid [N];
    bhq_pkg::key_t        cell_data  [N];
    logic                 cell_gt    [N];
    logic                 cell_vnext [N];
    bhq_pkg::key_t        cell_dnext [N];

    bhq_pkg::cell_ctrl_t  ctrl;
    bhq_pkg::count_t      count_reg;
    bhq_pkg::count_t      count_next;
    bhq_pkg::status_t     status_next;
    logic signed [31:0]   popped_next;
    logic signed [31:0]   top_next;

    logic                 out_valid_reg;
    logic signed [31:0]   popped_reg;
    logic signed [31:0]   top_reg;
    logic [6:0]           count_out_reg;
    bhq_pkg::status_t     status_reg;

    logic accept;
    logic is_pop;
    logic empty;
    logic full;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign is_pop   = (bhq_pkg::kind_t'(kind) == bhq_pkg::KIND_POP);
    assign empty    = !cell_valid[0];
    assign full     = cell_valid[N-1];

    always_comb
    begin
        ctrl.key    = bhq_pkg::to_key(value);
        ctrl.push   = 1'b0;
        ctrl.pop    = 1'b0;
        status_next = bhq_pkg::ST_OK;
        count_next  = count_reg;
        popped_next = '0;
        if (is_pop)
        begin
            if (empty)
            begin
                status_next = bhq_pkg::ST_EMPTY;
            end
            else
            begin
                ctrl.pop    = accept;
                count_next  = count_reg - bhq_pkg::count_t'(1);
                popped_next = bhq_pkg::from_key(cell_data[0]);
            end
        end
        else
        begin
            if (full)
            begin
                status_next = bhq_pkg::ST_FULL;
            end
            else
            begin
                ctrl.push  = accept;
                count_next = count_reg + bhq_pkg::count_t'(1);
            end
        end
        top_next = cell_vnext[0] ? bhq_pkg::from_key(cell_dnext[0]) : '0;
    end

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic          pv;
        logic          pg;
        bhq_pkg::key_t pd;
        logic          nv;
        bhq_pkg::key_t nd;

        // row ends: an always valid, never smaller slot before, an empty slot after
        if (i == 0)
        begin : g_head
            assign pv = 1'b1;
            assign pg = 1'b0;
            assign pd = '0;
        end
        else
        begin : g_body
            assign pv = cell_valid[i-1];
            assign pg = cell_gt[i-1];
            assign pd = cell_data[i-1];
        end

        if (i == N - 1)
        begin : g_tail
            assign nv = 1'b0;
            assign nd = '0;
        end
        else
        begin : g_link
            assign nv = cell_valid[i+1];
            assign nd = cell_data[i+1];
        end

        bhq_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .prev_valid (pv),
            .prev_gt    (pg),
            .prev_data  (pd),
            .next_valid (nv),
            .next_data  (nd),
            .valid      (cell_valid[i]),
            .data       (cell_data[i]),
            .gt         (cell_gt[i]),
            .valid_next (cell_vnext[i]),
            .data_next  (cell_dnext[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            popped_reg    <= popped_next;
            top_reg       <= top_next;
            count_out_reg <= 7'(count_next);
            status_reg    <= status_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign popped_value = popped_reg;
    assign top_value    = top_reg;
    assign entry_count  = count_out_reg;
    assign status       = status_reg;

endmodule

`default_nettype wire

@@ tb/sv/binary_max_heap_queue_tb.sv @@
// testbench for the binary max heap queue: heap tracker, drivers and result checks
`timescale 1ns / 1ps

module binary_max_heap_queue_tb;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SEG_ITEMS   = 60;

    typedef struct
    {
        logic signed [31:0] popped;
        logic signed [31:0] top;
        bhq_pkg::count_t    count;
        bhq_pkg::status_t   status;
    } heap_answer_t;

    // follows the heap contents item by item and holds the answers still owed
    class heap_tracker;
        bhq_pkg::key_t slots[bhq_pkg::CAPACITY];
        int            fill;
        heap_answer_t  owed[$];
        int            errors;
        int            results_seen;
        int            n_push;
        int            n_pop;
        int            n_empty;
        int            n_full;
        int            peak;

        function new();
            fill = 0;
            errors = 0;
            results_seen = 0;
            n_push = 0;
            n_pop = 0;
            n_empty = 0;
            n_full = 0;
            peak = 0;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 50)
                $display("mismatch: %s", msg);
        endtask

        function void swap_slots(int a, int b);
            bhq_pkg::key_t t;
            t = slots[a];
            slots[a] = slots[b];
            slots[b] = t;
        endfunction

        function void insert_key(bhq_pkg::key_t k);
            int pos;
            int up;
            pos = fill;
            slots[pos] = k;
            fill++;
            while (pos > 0)
            begin
                up = (pos - 1) / 2;
                if (slots[pos] <= slots[up])
                    break;
                swap_slots(pos, up);
                pos = up;
            end
        endfunction

        function bhq_pkg::key_t remove_top();
            bhq_pkg::key_t top;
            int            pos;
            int            left;
            int            best;
            top = slots[0];
            fill--;
            slots[0] = slots[fill];
            pos = 0;
            forever
            begin
                left = 2 * pos + 1;
                if (left >= fill)
                    break;
                best = left;
                // equal children keep the left one
                if (left + 1 < fill && slots[left + 1] > slots[left])
                    best = left + 1;
                if (slots[best] <= slots[pos])
                    break;
                swap_slots(best, pos);
                pos = best;
            end
            return top;
        endfunction

        function void take_request(logic k, logic signed [31:0] v);
            heap_answer_t a;
            a.popped = '0;
            a.status = bhq_pkg::ST_OK;
            if (k == bhq_pkg::KIND_PUSH)
            begin
                if (fill >= bhq_pkg::CAPACITY)
                begin
                    a.status = bhq_pkg::ST_FULL;
                    n_full++;
                end
                else
                begin
                    insert_key(bhq_pkg::key_t'(v));
                    n_push++;
                end
            end
            else
            begin
                if (fill == 0)
                begin
                    a.status = bhq_pkg::ST_EMPTY;
                    n_empty++;
                end
                else
                begin
                    a.popped = 32'(remove_top());
                    n_pop++;
                end
            end
            if (fill > peak)
                peak = fill;
            a.top = (fill > 0) ? 32'(slots[0]) : '0;
            a.count = bhq_pkg::count_t'(fill);
            owed.insert(owed.size(), a);
        endfunction

        task match_result(logic signed [31:0] popped, logic signed [31:0] top,
                          logic [6:0] cnt, logic [1:0] st);
            heap_answer_t want;
            results_seen++;
            if (owed.size() == 0)
            begin
                report($sformatf("result %0d arrived with no item pending", results_seen));
            end
            else
            begin
                want = owed.pop_front();
                if (popped !== want.popped)
                    report($sformatf("result %0d popped_value %0d, want %0d",
                                     results_seen, popped, want.popped));
                if (top !== want.top)
                    report($sformatf("result %0d top_value %0d, want %0d",
                                     results_seen, top, want.top));
                if (cnt !== want.count)
                    report($sformatf("result %0d entry_count %0d, want %0d",
                                     results_seen, cnt, want.count));
                if (st !== want.status)
                    report($sformatf("result %0d status %0d, want %s",
                                     results_seen, st, want.status.name()));
            end
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               kind;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] popped_value;
    logic signed [31:0] top_value;
    logic [6:0]         entry_count;
    logic [1:0]         status;

    heap_tracker tracker;
    int          cycles;
    int          tx_idle_max;
    int          rx_idle_max;
    int          rx_hold_once;

    binary_max_heap_queue uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .popped_value (popped_value),
        .top_value    (top_value),
        .entry_count  (entry_count),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    initial
    begin
        tracker = new();
        cycles = 0;
        tx_idle_max = 0;
        rx_idle_max = 0;
        rx_hold_once = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // values seen here are the ones that stood before this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                tracker.take_request(kind, value);
            if (out_valid && !out_stall)
                tracker.match_result(popped_value, top_value, entry_count, status);
        end
    end

    // result side: stall for a drawn number of cycles, then take one item
    initial
    begin
        int gap;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold_once > 0)
            begin
                gap = rx_hold_once;
                rx_hold_once = 0;
            end
            else
            begin
                gap = $urandom_range(0, rx_idle_max);
            end
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    task send_item(bhq_pkg::kind_t k, logic signed [31:0] v);
        int gap;
        gap = $urandom_range(0, tx_idle_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        value <= v;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
    endtask

    // the last item was taken at this edge, so the input goes idle first
    task wait_drained();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom;
        // narrow range gives plenty of equal keys
        if (r < 85)
            return $urandom_range(0, 8) - 4;
        case ($urandom_range(0, 3))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sh0;
            default: return -32'sd1;
        endcase
    endfunction

    task run_segment(int items, int push_pct);
        int i;
        for (i = 0; i < items; i++)
        begin
            if ($urandom_range(1, 100) <= push_pct)
                send_item(bhq_pkg::KIND_PUSH, pick_value());
            else
                send_item(bhq_pkg::KIND_POP, $urandom);
        end
    endtask

    initial
    begin
        int i;
        int seg;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        kind <= bhq_pkg::KIND_PUSH;
        value <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pop, extremes, equal keys, drain, empty pop again
        rx_idle_max = 18;
        send_item(bhq_pkg::KIND_POP, 32'sh0);
        send_item(bhq_pkg::KIND_PUSH, 32'sh0);
        send_item(bhq_pkg::KIND_PUSH, 32'sh7fffffff);
        send_item(bhq_pkg::KIND_PUSH, 32'sh80000000);
        send_item(bhq_pkg::KIND_PUSH, -32'sd1);
        send_item(bhq_pkg::KIND_PUSH, 32'sd1);
        for (i = 0; i < 4; i++)
            send_item(bhq_pkg::KIND_PUSH, 32'sd5);
        for (i = 0; i < 9; i++)
            send_item(bhq_pkg::KIND_POP, 32'shffffffff);
        send_item(bhq_pkg::KIND_POP, 32'sh0);

        // fill past capacity, then drain past empty
        tx_idle_max = 0;
        rx_idle_max = 0;
        run_segment(bhq_pkg::CAPACITY + 6, 100);
        tx_idle_max = 18;
        rx_idle_max = 18;
        run_segment(bhq_pkg::CAPACITY + 6, 0);
        wait_drained();

        for (seg = 0; seg < 9; seg++)
        begin
            tx_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 18;
            rx_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 18;
            run_segment(SEG_ITEMS, $urandom_range(25, 75));
            if (seg == 4)
            begin
                // long result hold while items keep coming
                tx_idle_max = 0;
                rx_hold_once = 150;
                run_segment(30, 70);
                wait_drained();
            end
        end

        wait_drained();

        $display("%0d pushes, %0d pops, %0d pops on empty, %0d pushes on full",
                 tracker.n_push, tracker.n_pop, tracker.n_empty, tracker.n_full);
        $display("%0d results checked, deepest fill %0d of %0d",
                 tracker.results_seen, tracker.peak, bhq_pkg::CAPACITY);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ files.f @@
hdl/bhq_pkg.sv
hdl/bhq_cell.sv
hdl/binary_max_heap_queue.sv
tb/sv/binary_max_heap_queue_tb.sv
